/* design/njpl_pkg.sv */
// package for the nearest joint pixel labeler
// holds widths, item and table entry types, the joint colour table
// used by every module of the block

package njpl_pkg;

   localparam int NUM_JOINTS_DEF  = 15;
   localparam int MAX_COLUMNS_DEF = 2048;
   localparam int MAX_ROWS_DEF    = 2048;

   localparam int COORD_W  = 12;
   localparam int DEPTH_W  = 16;
   localparam int JIDX_W   = 4;
   localparam int COLOUR_W = 8;

   localparam int SQC_W  = 24;
   localparam int SQD_W  = 32;
   localparam int DIST_W = 33;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic                kind;
      logic                wr_en;
      logic [JIDX_W-1:0]   idx;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [DEPTH_W-1:0]  dep;
      logic                ok;
   } njpl_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [DEPTH_W-1:0] dep;
   } njpl_joint_type;

   typedef struct packed {
      logic          push;
      njpl_item_type item;
   } njpl_push_type;

   function automatic logic [3*COLOUR_W-1:0] palette(input logic [JIDX_W-1:0] i);
      logic [3*COLOUR_W-1:0] c;
      case (i)
         4'd0:    c = {8'd255, 8'd0,   8'd0};
         4'd1:    c = {8'd0,   8'd255, 8'd0};
         4'd2:    c = {8'd0,   8'd0,   8'd255};
         4'd3:    c = {8'd0,   8'd255, 8'd255};
         4'd4:    c = {8'd255, 8'd0,   8'd255};
         4'd5:    c = {8'd255, 8'd255, 8'd0};
         4'd6:    c = {8'd0,   8'd128, 8'd128};
         4'd7:    c = {8'd128, 8'd0,   8'd128};
         4'd8:    c = {8'd128, 8'd128, 8'd0};
         4'd9:    c = {8'd255, 8'd255, 8'd255};
         4'd10:   c = {8'd128, 8'd128, 8'd128};
         4'd11:   c = {8'd255, 8'd0,   8'd128};
         4'd12:   c = {8'd0,   8'd128, 8'd255};
         4'd13:   c = {8'd128, 8'd0,   8'd255};
         4'd14:   c = {8'd128, 8'd255, 8'd0};
         default: c = {8'd255, 8'd128, 8'd0};
      endcase
      return c;
   endfunction

endpackage

/* design/njpl_front.sv */
// front end: takes request items and classifies them
// decides table write enable and whether a pixel gets labeled, uses njpl_pkg

module njpl_front #(
   parameter int NUM_JOINTS  = njpl_pkg::NUM_JOINTS_DEF,
   parameter int MAX_COLUMNS = njpl_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = njpl_pkg::MAX_ROWS_DEF
) (
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [njpl_pkg::JIDX_W-1:0]       req_joint_index,
   input  logic signed [njpl_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [njpl_pkg::COORD_W-1:0] req_coord_y,
   input  logic [njpl_pkg::DEPTH_W-1:0]      req_depth,
   input  logic                              req_mask_set,
   input  logic                              queue_full,
   output njpl_pkg::njpl_push_type           push
);

   localparam int CMP_W = njpl_pkg::COORD_W + 1;

   logic in_x;
   logic in_y;

   assign in_x = !req_coord_x[njpl_pkg::COORD_W-1] &&
                 ({1'b0, req_coord_x} < CMP_W'(MAX_COLUMNS));
   assign in_y = !req_coord_y[njpl_pkg::COORD_W-1] &&
                 ({1'b0, req_coord_y} < CMP_W'(MAX_ROWS));

   assign req_ready = !queue_full;

   always_comb begin
      push.push      = req_valid && !queue_full;
      push.item.kind = req_kind;
      push.item.wr_en = ({1'b0, req_joint_index} < (njpl_pkg::JIDX_W+1)'(NUM_JOINTS));
      push.item.idx  = req_joint_index;
      push.item.x    = req_coord_x;
      push.item.y    = req_coord_y;
      push.item.dep  = req_depth;
      push.item.ok   = req_mask_set && (req_depth != '0) && in_x && in_y;
   end

endmodule

/* design/njpl_queue.sv */
// short item queue between front and back end
// two entries of njpl_item_type, uses njpl_pkg

module njpl_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  njpl_pkg::njpl_push_type  push,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output njpl_pkg::njpl_item_type  pop_item
);

   njpl_pkg::njpl_item_type              entries_ff [0:njpl_pkg::QDEPTH-1];
   njpl_pkg::njpl_item_type              entries_in;
   logic [njpl_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [njpl_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [njpl_pkg::QCNT_W-1:0]          count_ff, count_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign full     = (count_ff == njpl_pkg::QCNT_W'(njpl_pkg::QDEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];
   assign do_push  = push.push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      entries_in = push.item;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= entries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/njpl_back.sv */
// back end: joint table, sequential nearest joint search, result register
// one joint per cycle through a multiply stage and a sum and compare stage, uses njpl_pkg

module njpl_back #(
   parameter int NUM_JOINTS = njpl_pkg::NUM_JOINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  njpl_pkg::njpl_item_type             q_item,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [njpl_pkg::COORD_W-1:0] rsp_pixel_x,
   output logic signed [njpl_pkg::COORD_W-1:0] rsp_pixel_y,
   output logic                                rsp_labeled,
   output logic [njpl_pkg::JIDX_W-1:0]         rsp_joint_label,
   output logic [njpl_pkg::COLOUR_W-1:0]       rsp_colour_0,
   output logic [njpl_pkg::COLOUR_W-1:0]       rsp_colour_1,
   output logic [njpl_pkg::COLOUR_W-1:0]       rsp_colour_2
);

   localparam int TW  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int CW  = njpl_pkg::COORD_W;
   localparam int DW  = njpl_pkg::DEPTH_W;
   localparam int JW  = njpl_pkg::JIDX_W;
   localparam int KW  = njpl_pkg::COLOUR_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } njpl_state_type;

   njpl_state_type             state_ff, state_in;
   njpl_pkg::njpl_joint_type   table_ff [0:NUM_JOINTS-1];
   njpl_pkg::njpl_item_type    cur_ff, cur_in;
   logic [JW-1:0]              k_ff, k_in;
   logic                       pv_ff, pv_in;
   logic [JW-1:0]              pk_ff, pk_in;
   logic [njpl_pkg::SQC_W-1:0] px_ff, px_in;
   logic [njpl_pkg::SQC_W-1:0] py_ff, py_in;
   logic [njpl_pkg::SQD_W-1:0] pd_ff, pd_in;
   logic [njpl_pkg::DIST_W-1:0] best_d_ff, best_d_in;
   logic [JW-1:0]              best_k_ff, best_k_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]              rsp_x_ff, rsp_x_in;
   logic [CW-1:0]              rsp_y_ff, rsp_y_in;
   logic                       rsp_lab_ff, rsp_lab_in;
   logic [JW-1:0]              rsp_label_ff, rsp_label_in;
   logic [3*KW-1:0]            rsp_col_ff, rsp_col_in;

   njpl_pkg::njpl_joint_type   joint;
   logic                       tbl_we;
   logic [CW:0]                dx, dy;
   logic [DW:0]                dd;
   logic [CW-1:0]              ax, ay;
   logic [DW-1:0]              ad;
   logic [njpl_pkg::DIST_W-1:0] dist_sum;
   logic                       slot_free;
   logic                       last_k;

   assign joint     = table_ff[k_ff[TW-1:0]];
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign tbl_we    = q_pop && (q_item.kind == njpl_pkg::KIND_LOAD) && q_item.wr_en;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_k    = (k_ff == JW'(NUM_JOINTS - 1));

   // absolute differences and squares of the joint under scan
   always_comb begin
      dx = {cur_ff.x[CW-1], cur_ff.x} - {joint.col[CW-1], joint.col};
      dy = {cur_ff.y[CW-1], cur_ff.y} - {joint.row[CW-1], joint.row};
      dd = {1'b0, cur_ff.dep} - {1'b0, joint.dep};
      ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
      ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];
      ad = dd[DW] ? DW'(-dd) : dd[DW-1:0];
      px_in = njpl_pkg::SQC_W'(ax) * njpl_pkg::SQC_W'(ax);
      py_in = njpl_pkg::SQC_W'(ay) * njpl_pkg::SQC_W'(ay);
      pd_in = njpl_pkg::SQD_W'(ad) * njpl_pkg::SQD_W'(ad);
      pv_in = (state_ff == ST_SCAN);
      pk_in = k_ff;
   end

   // running minimum, ties keep the lower index
   always_comb begin
      dist_sum = njpl_pkg::DIST_W'(px_ff) + njpl_pkg::DIST_W'(py_ff) +
                 njpl_pkg::DIST_W'(pd_ff);
      best_d_in = best_d_ff;
      best_k_in = best_k_ff;
      if (pv_ff && ((pk_ff == '0) || (dist_sum < best_d_ff))) begin
         best_d_in = dist_sum;
         best_k_in = pk_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            k_in = '0;
            if (q_pop) begin
               cur_in = q_item;
               if (q_item.kind == njpl_pkg::KIND_PIXEL) begin
                  state_in = q_item.ok ? ST_SCAN : ST_OUT;
               end
            end
         end
         ST_SCAN: begin
            k_in = k_ff + 1'b1;
            if (last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_lab_in   = rsp_lab_ff;
      rsp_label_in = rsp_label_ff;
      rsp_col_in   = rsp_col_ff;
      if ((state_ff == ST_OUT) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = cur_ff.x;
         rsp_y_in     = cur_ff.y;
         rsp_lab_in   = cur_ff.ok;
         rsp_label_in = cur_ff.ok ? best_k_ff : '0;
         rsp_col_in   = cur_ff.ok ? njpl_pkg::palette(best_k_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_JOINTS; i++) begin
            table_ff[i] <= '0;
         end
      end else if (tbl_we) begin
         table_ff[q_item.idx[TW-1:0]] <= '{col: q_item.x, row: q_item.y, dep: q_item.dep};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      pk_ff        <= pk_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pd_ff        <= pd_in;
      best_d_ff    <= best_d_in;
      best_k_ff    <= best_k_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_lab_ff   <= rsp_lab_in;
      rsp_label_ff <= rsp_label_in;
      rsp_col_ff   <= rsp_col_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_labeled     = rsp_lab_ff;
   assign rsp_joint_label = rsp_label_ff;
   assign rsp_colour_0    = rsp_col_ff[3*KW-1:2*KW];
   assign rsp_colour_1    = rsp_col_ff[2*KW-1:KW];
   assign rsp_colour_2    = rsp_col_ff[KW-1:0];

endmodule

/* design/nearest_joint_pixel_labeler_core.sv */
// top level of the nearest joint pixel labeler
// instantiates njpl_front, njpl_queue and njpl_back, uses njpl_pkg
//
// usage: the req channel carries load items (kind 0) that write one joint's
// column, row and depth into the joint table, and pixel items (kind 1).
// every pixel item gives exactly one item on the rsp channel, a load gives none.
// a pixel outside the frame, masked or with zero depth comes back unlabeled
// and black; otherwise it gets the index and colour of its nearest joint.
// items pass a two-entry queue, so req_ready stays high while the back end
// works until that queue fills.
// a labeled pixel passes from the queue through the scan of every joint, a
// drain state and the output state to rsp; an unlabeled pixel goes from the
// queue straight to the output state. the back end checks one joint per cycle
// with one distance unit and takes a new item from the queue only when it is
// back in idle, after it has passed the last one to the output register.
// reset clears the joint table to zero, empties the queue and drops rsp_valid.
// a stalled rsp holds its item in the output register; the back end waits,
// and the queue then fills and drops req_ready.

module nearest_joint_pixel_labeler_core #(
   parameter int NUM_JOINTS  = njpl_pkg::NUM_JOINTS_DEF,
   parameter int MAX_COLUMNS = njpl_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = njpl_pkg::MAX_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [njpl_pkg::JIDX_W-1:0]         req_joint_index,
   input  logic signed [njpl_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [njpl_pkg::COORD_W-1:0] req_coord_y,
   input  logic [njpl_pkg::DEPTH_W-1:0]        req_depth,
   input  logic                                req_mask_set,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [njpl_pkg::COORD_W-1:0] rsp_pixel_x,
   output logic signed [njpl_pkg::COORD_W-1:0] rsp_pixel_y,
   output logic                                rsp_labeled,
   output logic [njpl_pkg::JIDX_W-1:0]         rsp_joint_label,
   output logic [njpl_pkg::COLOUR_W-1:0]       rsp_colour_0,
   output logic [njpl_pkg::COLOUR_W-1:0]       rsp_colour_1,
   output logic [njpl_pkg::COLOUR_W-1:0]       rsp_colour_2
);

   njpl_pkg::njpl_push_type push;
   njpl_pkg::njpl_item_type q_item;
   logic                    q_full;
   logic                    q_empty;
   logic                    q_pop;

   njpl_front #(
      .NUM_JOINTS  (NUM_JOINTS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_joint_index (req_joint_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_depth       (req_depth),
      .req_mask_set    (req_mask_set),
      .queue_full      (q_full),
      .push            (push)
   );

   njpl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_item (q_item)
   );

   njpl_back #(
      .NUM_JOINTS (NUM_JOINTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_labeled     (rsp_labeled),
      .rsp_joint_label (rsp_joint_label),
      .rsp_colour_0    (rsp_colour_0),
      .rsp_colour_1    (rsp_colour_1),
      .rsp_colour_2    (rsp_colour_2)
   );

endmodule
